@@ rtl/assert_macros.svh @@
// assertion macros used by the ict_ctrl sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, disabled during reset
`define ICT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked in the cycle after the antecedent, disabled during reset
`define ICT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ict_pkg.sv @@
// types, constants and helpers for the inode cache table
package ict_pkg;

    localparam int SLOTS_DEFAULT = 64;
    localparam int OFFSET_W      = 3;
    localparam logic [7:0] COUNT_MAX = 8'd255;

    localparam logic ACT_ACQUIRE = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        STAT_HIT         = 3'd0,
        STAT_CLAIMED     = 3'd1,
        STAT_FULL        = 3'd2,
        STAT_STILL_USED  = 3'd3,
        STAT_FREED_CLEAN = 3'd4,
        STAT_WRITE_BACK  = 3'd5,
        STAT_BAD_RELEASE = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_CLAIM,
        FSM_RESP
    } fsm_t;

    typedef struct packed {
        logic        action;
        logic [7:0]  device;
        logic [23:0] inode_number;
        logic [5:0]  slot;
        logic        modified;
    } request_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  result_slot;
        logic [7:0]  count_now;
        logic [31:0] disk_block;
        logic [2:0]  block_offset;
    } result_t;

    // one slot of the table as it travels round the ring
    typedef struct packed {
        logic        valid;
        logic [7:0]  device;
        logic [23:0] inode;
        logic [7:0]  count;
        logic        dirty;
    } entry_t;

    // disk block of an inode, eight inodes per block, inode counted from one
    function automatic logic [31:0] ict_block(input logic [23:0] ino,
                                              input logic [31:0] base);
        logic [23:0] idx;
        idx = ino - 24'd1;
        return base + 32'(idx >> OFFSET_W);
    endfunction

    // position of an inode within its disk block
    function automatic logic [2:0] ict_offset(input logic [23:0] ino);
        logic [23:0] idx;
        idx = ino - 24'd1;
        return idx[OFFSET_W-1:0];
    endfunction

endpackage

@@ rtl/ict_cell.sv @@
// one slot cell of the rotating table ring
module ict_cell
    import ict_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   shift,
    input  entry_t d,
    output entry_t q
);

    entry_t entry_reg;
    entry_t entry_next;

    // take the neighbour's entry while the ring turns
    always_comb
    begin
        entry_next = entry_reg;
        if (shift)
        begin
            entry_next = d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign q = entry_reg;

endmodule

@@ rtl/ict_ctrl.sv @@
// sequencer and head-of-ring evaluation for the inode cache table
`include "assert_macros.svh"

module ict_ctrl
    import ict_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  request_t    request,
    output logic        busy,
    output logic        done,
    output result_t     result,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    input  entry_t      head,
    output entry_t      head_next,
    output logic        shift
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    fsm_t              state_reg, state_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    request_t          req_reg, req_next;
    logic              found_reg, found_next;
    logic              free_found_reg, free_found_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    result_t           res_reg, res_next;
    logic [31:0]       table_start_reg, table_start_next;

    logic              last_pos;
    logic              at_slot;
    logic              in_range;
    logic              dirty_now;
    logic [7:0]        count_dec;

    assign last_pos  = (pos_reg == IDX_W'(SLOTS - 1));
    assign at_slot   = (16'(pos_reg) == 16'(req_reg.slot));
    assign in_range  = ({26'd0, request.slot} < 32'(SLOTS));
    assign dirty_now = head.dirty | req_reg.modified;
    assign count_dec = head.count - 8'd1;

    // configuration register
    always_comb
    begin
        table_start_next = table_start_reg;
        if (cfg_we)
        begin
            table_start_next = cfg_data;
        end
    end

    // next state, head update and result
    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        req_next        = req_reg;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        res_next        = res_reg;
        head_next       = head;
        shift           = 1'b0;
        done            = 1'b0;
        busy            = (state_reg != FSM_IDLE);

        case (state_reg)
            FSM_IDLE:
            begin
                if (start)
                begin
                    req_next        = request;
                    pos_next        = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    free_idx_next   = '0;
                    res_next        = '0;
                    if (request.action == ACT_ACQUIRE)
                    begin
                        res_next.status = STAT_FULL;
                        state_next      = FSM_SCAN;
                    end
                    else
                    begin
                        res_next.status      = STAT_BAD_RELEASE;
                        res_next.result_slot = request.slot;
                        state_next           = in_range ? FSM_SCAN : FSM_RESP;
                    end
                end
            end

            FSM_SCAN:
            begin
                shift    = 1'b1;
                pos_next = last_pos ? '0 : pos_reg + IDX_W'(1);
                if (req_reg.action == ACT_ACQUIRE)
                begin
                    // first matching slot takes the hit
                    if (!found_reg && head.valid && head.device == req_reg.device
                        && head.inode == req_reg.inode_number)
                    begin
                        found_next = 1'b1;
                        if (head.count != COUNT_MAX)
                        begin
                            head_next.count = head.count + 8'd1;
                        end
                        res_next.status      = STAT_HIT;
                        res_next.result_slot = 6'(pos_reg);
                        res_next.count_now   = head_next.count;
                    end
                    // remember the lowest free slot for a claim
                    if (!free_found_reg && head.count == 8'd0)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = pos_reg;
                    end
                end
                else if (at_slot && head.count != 8'd0)
                begin
                    head_next.count    = count_dec;
                    head_next.dirty    = dirty_now;
                    res_next.count_now = count_dec;
                    if (count_dec != 8'd0)
                    begin
                        res_next.status = STAT_STILL_USED;
                    end
                    else if (dirty_now)
                    begin
                        res_next.status       = STAT_WRITE_BACK;
                        res_next.disk_block   = ict_block(head.inode, table_start_reg);
                        res_next.block_offset = ict_offset(head.inode);
                        head_next.dirty       = 1'b0;
                    end
                    else
                    begin
                        res_next.status = STAT_FREED_CLEAN;
                    end
                end
                if (last_pos)
                begin
                    if (req_reg.action == ACT_ACQUIRE && !found_next && free_found_next)
                    begin
                        state_next = FSM_CLAIM;
                    end
                    else
                    begin
                        state_next = FSM_RESP;
                    end
                end
            end

            FSM_CLAIM:
            begin
                shift    = 1'b1;
                pos_next = last_pos ? '0 : pos_reg + IDX_W'(1);
                if (pos_reg == free_idx_reg)
                begin
                    head_next.valid       = 1'b1;
                    head_next.device      = req_reg.device;
                    head_next.inode       = req_reg.inode_number;
                    head_next.count       = 8'd1;
                    head_next.dirty       = 1'b0;
                    res_next.status       = STAT_CLAIMED;
                    res_next.result_slot  = 6'(pos_reg);
                    res_next.count_now    = 8'd1;
                    res_next.disk_block   = ict_block(req_reg.inode_number, table_start_reg);
                    res_next.block_offset = ict_offset(req_reg.inode_number);
                end
                if (last_pos)
                begin
                    state_next = FSM_RESP;
                end
            end

            FSM_RESP:
            begin
                done       = 1'b1;
                state_next = FSM_IDLE;
            end

            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= FSM_IDLE;
            pos_reg         <= '0;
            found_reg       <= 1'b0;
            free_found_reg  <= 1'b0;
            table_start_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            pos_reg         <= pos_next;
            found_reg       <= found_next;
            free_found_reg  <= free_found_next;
            table_start_reg <= table_start_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        free_idx_reg <= free_idx_next;
        res_reg      <= res_next;
    end

    assign result = res_reg;

    // ring must be back in slot order whenever idle
    `ICT_ASSERT(a_idle_aligned, (state_reg == FSM_IDLE) |-> (pos_reg == '0), "ring misaligned at idle")
    // the ring only turns during a pass
    `ICT_ASSERT(a_shift_busy, shift |-> (state_reg == FSM_SCAN || state_reg == FSM_CLAIM), "ring turned outside a pass")
    // an accepted item leaves the block busy
    `ICT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "item accepted but not busy")
    // after the result strobe the block is free again
    `ICT_ASSERT_NEXT(a_done_free, done, !busy && !done, "result strobe not followed by idle")

endmodule

@@ rtl/inode_cache_table_unit.sv @@
// top level of the inode cache table: ring of slot cells and its sequencer
//
// Commands are taken when start is high and busy is low; each gives exactly one result item,
// shown on result for one cycle with done high, and the receiver cannot stall it. The slot
// table is a ring of SLOTS cells that turns by one place per cycle during a pass, past a single
// evaluation point at its head, so cost scales with the table size: an acquire that misses and
// claims a slot makes a scan pass then a claim pass, an acquire that hits or finds the table full
// and an in-range release make one pass, and a release of a slot beyond the table makes none.
// No new item is taken until done. The user must write inode_table_start through cfg_we/cfg_data
// while the block is idle; the block does not enforce it. All slots are clear after reset.
module inode_cache_table_unit
    import ict_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  request_t    request,
    output logic        busy,
    output logic        done,
    output result_t     result,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data
);

    entry_t cell_q [SLOTS];
    entry_t head_next;
    logic   shift;

    // sequencer sees the head cell and feeds the tail
    ict_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .head      (cell_q[0]),
        .head_next (head_next),
        .shift     (shift)
    );

    // ring of slot cells, each passing its entry towards the head
    for (genvar k = 0; k < SLOTS; k++)
    begin : g_cell
        entry_t cell_d;
        if (k == SLOTS - 1)
        begin : g_tail
            assign cell_d = head_next;
        end
        else
        begin : g_body
            assign cell_d = cell_q[k+1];
        end
        ict_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (shift),
            .d     (cell_d),
            .q     (cell_q[k])
        );
    end

endmodule
